### hw/rtl/dist3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dist3_pkg
// Shared types and constants of the 3D distance pipeline.
// ----------------------------------------------------------------------------
package dist3_pkg;

  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_W     = 24;
  localparam int SQ_W       = 34;  // sum of three squares of 17-bit magnitudes
  localparam int ROOT_W     = 17;
  localparam int ROOT_STEPS = 17;
  localparam int NUM_W      = 32;  // plane numerator magnitude
  localparam int REM_W      = 18;

  typedef enum logic [1:0] {
    OP_LENGTH = 2'd0,
    OP_POINT  = 2'd1,
    OP_PLANE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             degen;
    logic [NUM_W-1:0] num;
  } sqrt_side_t;

  typedef struct packed {
    op_t               op;
    logic              degen;
    logic              sat;
    logic [ROOT_W-1:0] root;
  } div_side_t;

endpackage

### hw/rtl/distance_3d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_3d_unit
// Pipelined 3D vector length, point distance and point-to-plane distance.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_*    | input     | request: operation in tuser, P, Q, plane offset in tdata
//  out_*   | output    | distance in tdata, degenerate and saturated in tuser
//
// one request per cycle while no result waits on a low out_tready; made of 3 prep stages,
// 17 square-root stages, one overflow-check stage and 24 divider stages
// synchronous active-low reset clears only the valid bits
// the whole pipeline holds while a result waits and out_tready is low
// ----------------------------------------------------------------------------
module distance_3d_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // p_x, p_y, p_z, q_x, q_y, q_z, plane_offset
  input  logic [1:0]   in_tuser,  // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata, // distance
  output logic [1:0]   out_tuser  // degenerate, saturated
);

  localparam int CW = dist3_pkg::COORD_W;

  logic                 en;
  logic signed [CW-1:0] p [3];
  logic signed [CW-1:0] q [3];
  logic signed [CW-1:0] d;

  logic                              prep_valid;
  logic [dist3_pkg::SQ_W-1:0]        prep_sq;
  dist3_pkg::sqrt_side_t             prep_side;
  logic                              sqrt_valid;
  logic [dist3_pkg::ROOT_W-1:0]      sqrt_root;
  dist3_pkg::sqrt_side_t             sqrt_side;
  logic [dist3_pkg::DIST_W-1:0]      distance;
  logic                              degenerate;
  logic                              saturated;

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign p[i] = in_tdata[i*CW +: CW];
    assign q[i] = in_tdata[(i+3)*CW +: CW];
  end
  assign d = in_tdata[6*CW +: CW];

  dist3_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_op     (dist3_pkg::op_t'(in_tuser)),
    .in_p      (p),
    .in_q      (q),
    .in_d      (d),
    .out_valid (prep_valid),
    .out_sq_sum(prep_sq),
    .out_side  (prep_side)
  );

  dist3_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (prep_valid),
    .in_x     (prep_sq),
    .in_side  (prep_side),
    .out_valid(sqrt_valid),
    .out_root (sqrt_root),
    .out_side (sqrt_side)
  );

  dist3_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (sqrt_valid),
    .in_root       (sqrt_root),
    .in_side       (sqrt_side),
    .out_valid     (out_tvalid),
    .out_distance  (distance),
    .out_degenerate(degenerate),
    .out_saturated (saturated)
  );

  assign out_tdata = distance;
  assign out_tuser = {saturated, degenerate};

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && degenerate |-> distance == '0 && !saturated)
    else $error("degenerate result not zero");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && saturated |-> distance == '1)
    else $error("saturated result not at full scale");

  a_stall_only_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

endmodule

### hw/rtl/dist3_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dist3_prep
// Three stages: vector select, squares and plane products, sums.
// ----------------------------------------------------------------------------
module dist3_prep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  dist3_pkg::op_t                       in_op,
  input  logic signed [dist3_pkg::COORD_W-1:0] in_p [3],
  input  logic signed [dist3_pkg::COORD_W-1:0] in_q [3],
  input  logic signed [dist3_pkg::COORD_W-1:0] in_d,
  output logic                                 out_valid,
  output logic [dist3_pkg::SQ_W-1:0]           out_sq_sum,
  output dist3_pkg::sqrt_side_t                out_side
);

  localparam int CW = dist3_pkg::COORD_W;
  localparam int PW = 2 * CW;
  localparam int AW = PW + 2;

  // stage 1
  logic                 s1_valid_r;
  dist3_pkg::op_t       s1_op_r;
  logic signed [CW:0]   s1_v_r [3];
  logic signed [CW:0]   s1_v_nxt [3];
  logic signed [CW-1:0] s1_p_r [3];
  logic signed [CW-1:0] s1_q_r [3];
  logic signed [CW-1:0] s1_d_r;

  // stage 2
  logic                 s2_valid_r;
  dist3_pkg::op_t       s2_op_r;
  logic [2*CW+1:0]      s2_sq_r [3];
  logic [2*CW+1:0]      s2_sq_nxt [3];
  logic [CW:0]          s2_mag [3];
  logic signed [PW-1:0] s2_prod_r [3];
  logic signed [CW-1:0] s2_d_r;

  // stage 3
  logic                 s3_valid_r;
  logic [dist3_pkg::SQ_W-1:0] s3_sq_sum_r;
  dist3_pkg::sqrt_side_t      s3_side_r;
  logic [dist3_pkg::SQ_W-1:0] sq_sum_nxt;
  logic signed [AW-1:0]       expr_nxt;
  logic [AW-1:0]              expr_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (in_op)
        dist3_pkg::OP_LENGTH: s1_v_nxt[i] = (CW+1)'(in_p[i]);
        dist3_pkg::OP_POINT:  s1_v_nxt[i] = (CW+1)'(in_q[i]) - (CW+1)'(in_p[i]);
        default:              s1_v_nxt[i] = (CW+1)'(in_q[i]);
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_mag[i]    = s1_v_r[i][CW] ? (CW+1)'(-s1_v_r[i]) : (CW+1)'(s1_v_r[i]);
      s2_sq_nxt[i] = (2*CW+2)'(s2_mag[i]) * (2*CW+2)'(s2_mag[i]);
    end
  end

  always_comb begin
    sq_sum_nxt = dist3_pkg::SQ_W'(s2_sq_r[0]) + dist3_pkg::SQ_W'(s2_sq_r[1])
               + dist3_pkg::SQ_W'(s2_sq_r[2]);
    expr_nxt   = AW'(s2_prod_r[0]) + AW'(s2_prod_r[1]) + AW'(s2_prod_r[2])
               + (AW'(s2_d_r) <<< dist3_pkg::FRAC_BITS);
    expr_mag   = expr_nxt[AW-1] ? AW'(-expr_nxt) : AW'(expr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= in_op;
      s1_d_r  <= in_d;
      for (int i = 0; i < 3; i++) begin
        s1_v_r[i] <= s1_v_nxt[i];
        s1_p_r[i] <= in_p[i];
        s1_q_r[i] <= in_q[i];
      end
      s2_op_r <= s1_op_r;
      s2_d_r  <= s1_d_r;
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i]   <= s2_sq_nxt[i];
        s2_prod_r[i] <= PW'(s1_q_r[i]) * PW'(s1_p_r[i]);
      end
      s3_sq_sum_r     <= sq_sum_nxt;
      s3_side_r.op    <= s2_op_r;
      s3_side_r.degen <= (s2_op_r == dist3_pkg::OP_PLANE) && (sq_sum_nxt == '0);
      s3_side_r.num   <= expr_mag[dist3_pkg::NUM_W-1:0];
    end
  end

  assign out_valid  = s3_valid_r;
  assign out_sq_sum = s3_sq_sum_r;
  assign out_side   = s3_side_r;

endmodule

### hw/rtl/dist3_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dist3_sqrt
// Integer square root, one result bit per pipeline stage, rounds down.
// ----------------------------------------------------------------------------
module dist3_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [dist3_pkg::SQ_W-1:0]        in_x,
  input  dist3_pkg::sqrt_side_t             in_side,
  output logic                              out_valid,
  output logic [dist3_pkg::ROOT_W-1:0]      out_root,
  output dist3_pkg::sqrt_side_t             out_side
);

  localparam int N  = dist3_pkg::ROOT_STEPS;
  localparam int XW = dist3_pkg::SQ_W;
  localparam int RW = dist3_pkg::SQ_W + 1;

  logic                  valid_r [N];
  logic [XW-1:0]         x_r     [N];
  logic [RW-1:0]         res_r   [N];
  dist3_pkg::sqrt_side_t side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
    logic                  v_in;
    logic [XW-1:0]         x_in;
    logic [RW-1:0]         res_in;
    logic [RW-1:0]         trial;
    dist3_pkg::sqrt_side_t side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign x_in    = x_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (RW'(x_in) >= trial) begin
          x_r[k]   <= XW'(RW'(x_in) - trial);
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          x_r[k]   <= x_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = res_r[N-1][dist3_pkg::ROOT_W-1:0];
  assign out_side  = side_r[N-1];

endmodule

### hw/rtl/dist3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dist3_div
// Overflow check plus restoring divider, one quotient bit per stage,
// and the final result select.
// ----------------------------------------------------------------------------
module dist3_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [dist3_pkg::ROOT_W-1:0]      in_root,
  input  dist3_pkg::sqrt_side_t             in_side,
  output logic                              out_valid,
  output logic [dist3_pkg::DIST_W-1:0]      out_distance,
  output logic                              out_degenerate,
  output logic                              out_saturated
);

  localparam int N  = dist3_pkg::DIST_W;
  localparam int QW = dist3_pkg::DIST_W;
  localparam int EW = dist3_pkg::ROOT_W + dist3_pkg::DIST_W;
  localparam int MW = dist3_pkg::REM_W;

  logic                 e_valid_r;
  logic [MW-1:0]        e_rem_r;
  logic [QW-1:0]        e_w_r;
  dist3_pkg::div_side_t e_side_r;

  logic                 valid_r [N];
  logic [MW-1:0]        rem_r   [N];
  logic [QW-1:0]        w_r     [N];
  dist3_pkg::div_side_t side_r  [N];

  // quotient overflows 24 bits when num >= root * 2^24
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rem_r        <= MW'(in_side.num[dist3_pkg::NUM_W-1:QW]);
      e_w_r          <= in_side.num[QW-1:0];
      e_side_r.op    <= in_side.op;
      e_side_r.degen <= in_side.degen;
      e_side_r.root  <= in_root;
      e_side_r.sat   <= EW'(in_side.num) >= (EW'(in_root) << QW);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                 v_in;
    logic [MW-1:0]        rem_in;
    logic [QW-1:0]        w_in;
    dist3_pkg::div_side_t side_in;
    logic [MW-1:0]        t;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_in    = e_valid_r;
      assign rem_in  = e_rem_r;
      assign w_in    = e_w_r;
      assign side_in = e_side_r;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign w_in    = w_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign t  = {rem_in[MW-2:0], w_in[QW-1]};
    assign ge = t >= MW'(side_in.root);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        rem_r[k]  <= ge ? t - MW'(side_in.root) : t;
        w_r[k]    <= {w_in[QW-2:0], ge};
      end
    end
  end

  dist3_pkg::div_side_t fin;
  assign fin = side_r[N-1];

  always_comb begin
    out_distance   = '0;
    out_degenerate = 1'b0;
    out_saturated  = 1'b0;
    case (fin.op)
      dist3_pkg::OP_LENGTH, dist3_pkg::OP_POINT: begin
        out_distance = QW'(fin.root);
      end
      dist3_pkg::OP_PLANE: begin
        if (fin.degen) begin
          out_degenerate = 1'b1;
        end else if (fin.sat) begin
          out_saturated = 1'b1;
          out_distance  = '1;
        end else begin
          out_distance = w_r[N-1];
        end
      end
      default: begin
        out_distance = '0;
      end
    endcase
  end

  assign out_valid = valid_r[N-1];

endmodule
